### rtl/core/tdpu_pkg.sv
// ----------------------------------------------------------------------------
// tdpu_pkg
// Shared types and operation codes of the Thumb data-processing unit.
// ----------------------------------------------------------------------------
package tdpu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RegIdxW = 3;

  typedef logic [1:0] shift_kind_t;
  localparam shift_kind_t SH_LSL = 2'd0;
  localparam shift_kind_t SH_LSR = 2'd1;
  localparam shift_kind_t SH_ASR = 2'd2;
  localparam shift_kind_t SH_ROR = 2'd3;

  typedef logic [1:0] imm_op_t;
  localparam imm_op_t IMM_MOV = 2'd0;
  localparam imm_op_t IMM_CMP = 2'd1;
  localparam imm_op_t IMM_ADD = 2'd2;
  localparam imm_op_t IMM_SUB = 2'd3;

  typedef logic [3:0] alu_op_t;
  localparam alu_op_t ALU_AND = 4'h0;
  localparam alu_op_t ALU_EOR = 4'h1;
  localparam alu_op_t ALU_LSL = 4'h2;
  localparam alu_op_t ALU_LSR = 4'h3;
  localparam alu_op_t ALU_ASR = 4'h4;
  localparam alu_op_t ALU_ADC = 4'h5;
  localparam alu_op_t ALU_SBC = 4'h6;
  localparam alu_op_t ALU_ROR = 4'h7;
  localparam alu_op_t ALU_TST = 4'h8;
  localparam alu_op_t ALU_NEG = 4'h9;
  localparam alu_op_t ALU_CMP = 4'hA;
  localparam alu_op_t ALU_CMN = 4'hB;
  localparam alu_op_t ALU_ORR = 4'hC;
  localparam alu_op_t ALU_MUL = 4'hD;
  localparam alu_op_t ALU_BIC = 4'hE;
  localparam alu_op_t ALU_MVN = 4'hF;

  localparam logic [5:0] FMT4_PREFIX = 6'b010000;
  localparam logic [2:0] FMT12_TOP = 3'b000;
  localparam logic [2:0] FMT3_TOP = 3'b001;
  localparam logic [1:0] FMT2_SEL = 2'b11;

  typedef struct packed {
    logic [15:0] opcode;
    logic [DataW-1:0] reg_2_0;
    logic [DataW-1:0] reg_5_3;
    logic [DataW-1:0] reg_8_6;
    logic [DataW-1:0] reg_10_8;
    logic carry;
    logic overflow;
  } exec_in_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic [RegIdxW-1:0] dest_index;
    logic write_enable;
    logic flag_n;
    logic flag_z;
    logic flag_c;
    logic flag_v;
    logic unsupported;
  } exec_out_t;

endpackage

### rtl/core/tdpu_shifter.sv
// ----------------------------------------------------------------------------
// tdpu_shifter
// Barrel shifter with ARM carry-out rules for LSL, LSR, ASR and ROR.
// ----------------------------------------------------------------------------
module tdpu_shifter
  import tdpu_pkg::*;
(
  input  logic [DataW-1:0] value,
  input  shift_kind_t      kind,
  input  logic [7:0]       amount,
  input  logic             carry_in,
  output logic [DataW-1:0] shifted,
  output logic             carry_out
);

  logic             sign;
  logic             big;
  logic             exact;
  logic [4:0]       amt_lo;
  logic [DataW:0]   lsl_w;
  logic [DataW:0]   lsr_w;
  logic [DataW:0]   asr_w;
  logic [2*DataW-1:0] ror_w;

  assign sign   = value[DataW-1];
  assign amt_lo = amount[4:0];
  assign big    = (amount[7:5] != 3'd0);
  assign exact  = (amount == 8'd32);
  assign lsl_w  = {1'b0, value} << amt_lo;
  assign lsr_w  = {value, 1'b0} >> amt_lo;
  assign asr_w  = 33'($signed({value, 1'b0}) >>> amt_lo);
  assign ror_w  = {value, value} >> amt_lo;

  always_comb begin
    shifted   = value;
    carry_out = carry_in;
    if (amount != 8'd0) begin
      case (kind)
        SH_LSL: begin
          if (!big) begin
            shifted   = lsl_w[DataW-1:0];
            carry_out = lsl_w[DataW];
          end else begin
            shifted   = '0;
            carry_out = exact & value[0];
          end
        end
        SH_LSR: begin
          if (!big) begin
            shifted   = lsr_w[DataW:1];
            carry_out = lsr_w[0];
          end else begin
            shifted   = '0;
            carry_out = exact & sign;
          end
        end
        SH_ASR: begin
          if (!big) begin
            shifted   = asr_w[DataW:1];
            carry_out = asr_w[0];
          end else begin
            shifted   = {DataW{sign}};
            carry_out = sign;
          end
        end
        default: begin
          shifted   = ror_w[DataW-1:0];
          carry_out = ror_w[DataW-1];
        end
      endcase
    end
  end

endmodule

### rtl/core/tdpu_alu.sv
// ----------------------------------------------------------------------------
// tdpu_alu
// Decode and execute of Thumb formats 1 to 4 for one registered instruction.
// ----------------------------------------------------------------------------
module tdpu_alu
  import tdpu_pkg::*;
(
  input  exec_in_t  ex_in,
  output exec_out_t ex_out
);

  logic [15:0]      op;
  logic             is_fmt2;
  logic             is_fmt1;
  logic             is_fmt3;
  logic             is_fmt4;
  alu_op_t          alu_op;
  shift_kind_t      sh_kind;
  logic [7:0]       sh_amt;
  logic [4:0]       imm5;
  logic [DataW-1:0] sh_val;
  logic [DataW-1:0] sh_res;
  logic             sh_c;
  logic [DataW-1:0] add_a;
  logic [DataW-1:0] add_b;
  logic             add_ci;
  logic [DataW:0]   add_sum;
  logic [DataW-1:0] add_res;
  logic             add_v;
  logic [DataW-1:0] mul_res;
  logic [DataW-1:0] imm8;
  logic [DataW-1:0] b2;

  assign op      = ex_in.opcode;
  assign is_fmt2 = (op[15:13] == FMT12_TOP) && (op[12:11] == FMT2_SEL);
  assign is_fmt1 = (op[15:13] == FMT12_TOP) && !is_fmt2;
  assign is_fmt3 = (op[15:13] == FMT3_TOP);
  assign is_fmt4 = (op[15:10] == FMT4_PREFIX);
  assign alu_op  = op[9:6];
  assign imm5    = op[10:6];
  assign imm8    = {24'd0, op[7:0]};
  assign b2      = op[10] ? {29'd0, op[8:6]} : ex_in.reg_8_6;

  always_comb begin
    if (is_fmt1) begin
      sh_kind = op[12:11];
      sh_val  = ex_in.reg_5_3;
      if ((op[12:11] != SH_LSL) && (imm5 == 5'd0)) begin
        sh_amt = 8'd32;
      end else begin
        sh_amt = {3'd0, imm5};
      end
    end else begin
      sh_val  = ex_in.reg_2_0;
      sh_amt  = ex_in.reg_5_3[7:0];
      case (alu_op)
        ALU_LSL: sh_kind = SH_LSL;
        ALU_LSR: sh_kind = SH_LSR;
        ALU_ASR: sh_kind = SH_ASR;
        default: sh_kind = SH_ROR;
      endcase
    end
  end

  tdpu_shifter u_shifter (
    .value     (sh_val),
    .kind      (sh_kind),
    .amount    (sh_amt),
    .carry_in  (ex_in.carry),
    .shifted   (sh_res),
    .carry_out (sh_c)
  );

  always_comb begin
    add_a  = ex_in.reg_2_0;
    add_b  = ex_in.reg_5_3;
    add_ci = 1'b0;
    if (is_fmt2) begin
      add_a  = ex_in.reg_5_3;
      add_b  = op[9] ? ~b2 : b2;
      add_ci = op[9];
    end else if (is_fmt3) begin
      add_a  = ex_in.reg_10_8;
      add_b  = (op[12:11] == IMM_ADD) ? imm8 : ~imm8;
      add_ci = (op[12:11] != IMM_ADD);
    end else begin
      case (alu_op)
        ALU_ADC: begin
          add_ci = ex_in.carry;
        end
        ALU_SBC: begin
          add_b  = ~ex_in.reg_5_3;
          add_ci = ex_in.carry;
        end
        ALU_NEG: begin
          add_a  = '0;
          add_b  = ~ex_in.reg_5_3;
          add_ci = 1'b1;
        end
        ALU_CMP: begin
          add_b  = ~ex_in.reg_5_3;
          add_ci = 1'b1;
        end
        default: begin
          add_ci = 1'b0;
        end
      endcase
    end
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{DataW{1'b0}}, add_ci};
  assign add_res = add_sum[DataW-1:0];
  assign add_v   = (add_a[DataW-1] ^ add_res[DataW-1]) & (add_b[DataW-1] ^ add_res[DataW-1]);
  assign mul_res = ex_in.reg_2_0 * ex_in.reg_5_3;

  always_comb begin
    ex_out.result       = '0;
    ex_out.dest_index   = op[2:0];
    ex_out.write_enable = 1'b1;
    ex_out.flag_c       = ex_in.carry;
    ex_out.flag_v       = ex_in.overflow;
    ex_out.unsupported  = 1'b0;
    if (is_fmt2) begin
      ex_out.result = add_res;
      ex_out.flag_c = add_sum[DataW];
      ex_out.flag_v = add_v;
    end else if (is_fmt1) begin
      ex_out.result = sh_res;
      ex_out.flag_c = sh_c;
    end else if (is_fmt3) begin
      ex_out.dest_index = op[10:8];
      if (op[12:11] == IMM_MOV) begin
        ex_out.result = imm8;
      end else begin
        ex_out.result = add_res;
        ex_out.flag_c = add_sum[DataW];
        ex_out.flag_v = add_v;
      end
      if (op[12:11] == IMM_CMP) begin
        ex_out.write_enable = 1'b0;
      end
    end else if (is_fmt4) begin
      case (alu_op)
        ALU_AND, ALU_TST: ex_out.result = ex_in.reg_2_0 & ex_in.reg_5_3;
        ALU_EOR: ex_out.result = ex_in.reg_2_0 ^ ex_in.reg_5_3;
        ALU_ORR: ex_out.result = ex_in.reg_2_0 | ex_in.reg_5_3;
        ALU_BIC: ex_out.result = ex_in.reg_2_0 & ~ex_in.reg_5_3;
        ALU_MVN: ex_out.result = ~ex_in.reg_5_3;
        ALU_MUL: ex_out.result = mul_res;
        ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: begin
          ex_out.result = sh_res;
          ex_out.flag_c = sh_c;
        end
        default: begin
          ex_out.result = add_res;
          ex_out.flag_c = add_sum[DataW];
          ex_out.flag_v = add_v;
        end
      endcase
      if ((alu_op == ALU_TST) || (alu_op == ALU_CMP) || (alu_op == ALU_CMN)) begin
        ex_out.write_enable = 1'b0;
      end
    end else begin
      ex_out.dest_index   = '0;
      ex_out.write_enable = 1'b0;
      ex_out.unsupported  = 1'b1;
    end
    ex_out.flag_n = !ex_out.unsupported && ex_out.result[DataW-1];
    ex_out.flag_z = !ex_out.unsupported && (ex_out.result == '0);
  end

endmodule

### rtl/core/thumb_data_processing_unit.sv
// ----------------------------------------------------------------------------
// thumb_data_processing_unit
// Executes Thumb shift, add/subtract, immediate and register ALU instructions.
//
//   Port group   Direction   Beat contents
//   in_*         input       instruction halfword, four operand values, C, V
//   out_*        output      result, destination, write enable, flags, status
//
// An instruction beat is registered, executed, and its result registered.
// One beat is taken every cycle unless both registers are full and out_ready
// stalls; execute, 32 by 32 multiplier included, is combinational between the
// two registers. A stall on out_ready holds both registers, and in_ready falls
// only when both are full. rst_n clears both valid bits.
// ----------------------------------------------------------------------------
module thumb_data_processing_unit
  import tdpu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         in_opcode,
  input  logic [DataW-1:0]    in_reg_at_bits_2_0,
  input  logic [DataW-1:0]    in_reg_at_bits_5_3,
  input  logic [DataW-1:0]    in_reg_at_bits_8_6,
  input  logic [DataW-1:0]    in_reg_at_bits_10_8,
  input  logic                in_carry_in,
  input  logic                in_overflow_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DataW-1:0]    out_result,
  output logic [RegIdxW-1:0]  out_dest_index,
  output logic                out_write_enable,
  output logic                out_flag_n,
  output logic                out_flag_z,
  output logic                out_flag_c,
  output logic                out_flag_v,
  output logic                out_unsupported
);

  logic      s1_valid_r;
  logic      out_valid_r;
  exec_in_t  s1_data_r;
  exec_out_t out_data_r;
  exec_out_t ex_res;
  logic      out_load;
  logic      s1_load;

  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || out_load;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (!out_valid_r || out_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= '{opcode:   in_opcode,
                     reg_2_0:  in_reg_at_bits_2_0,
                     reg_5_3:  in_reg_at_bits_5_3,
                     reg_8_6:  in_reg_at_bits_8_6,
                     reg_10_8: in_reg_at_bits_10_8,
                     carry:    in_carry_in,
                     overflow: in_overflow_in};
    end
    if (out_load) begin
      out_data_r <= ex_res;
    end
  end

  tdpu_alu u_alu (
    .ex_in  (s1_data_r),
    .ex_out (ex_res)
  );

  assign out_valid        = out_valid_r;
  assign out_result       = out_data_r.result;
  assign out_dest_index   = out_data_r.dest_index;
  assign out_write_enable = out_data_r.write_enable;
  assign out_flag_n       = out_data_r.flag_n;
  assign out_flag_z       = out_data_r.flag_z;
  assign out_flag_c       = out_data_r.flag_c;
  assign out_flag_v       = out_data_r.flag_v;
  assign out_unsupported  = out_data_r.unsupported;

  a_unsup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unsupported) |->
      (!out_write_enable && (out_dest_index == '0) && !out_flag_n && !out_flag_z))
    else $error("unsupported result carries a write or N/Z");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_unsupported) |-> (out_flag_z == (out_result == '0)))
    else $error("Z flag does not match result");

  a_neg_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_unsupported) |-> (out_flag_n == out_result[DataW-1]))
    else $error("N flag does not match result");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("beat accepted while both stages are full and stalled");

endmodule

### tb/sv/thumb_data_processing_unit_test.sv
// ----------------------------------------------------------------------------
// thumb_data_processing_unit_test
// Self-checking testbench for the Thumb data-processing unit. A directed
// pass covers the shift, add/subtract, immediate and register ALU forms and
// unsupported opcodes. Random instruction streams follow, with random idle
// bursts on both channels, a long receiver hold-off and drain pauses. Every
// result beat is checked field by field against a behavioral prediction.
// ----------------------------------------------------------------------------
module thumb_data_processing_unit_test
  import tdpu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod = 10;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxReports = 10;
  localparam logic [15:0] OP_HI_REG_ADD = 16'h4448;
  localparam logic [15:0] OP_ALL_ONES = 16'hFFFF;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [15:0] in_opcode;
  logic [DataW-1:0] in_reg_at_bits_2_0;
  logic [DataW-1:0] in_reg_at_bits_5_3;
  logic [DataW-1:0] in_reg_at_bits_8_6;
  logic [DataW-1:0] in_reg_at_bits_10_8;
  logic in_carry_in;
  logic in_overflow_in;
  logic out_valid;
  logic out_ready;
  logic [DataW-1:0] out_result;
  logic [RegIdxW-1:0] out_dest_index;
  logic out_write_enable;
  logic out_flag_n;
  logic out_flag_z;
  logic out_flag_c;
  logic out_flag_v;
  logic out_unsupported;

  exec_out_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned stray_count = 0;
  int unsigned checked_count = 0;
  int unsigned unsupported_count = 0;
  int unsigned flag_only_count = 0;
  int unsigned instr_count = 0;
  int unsigned idle_cycles = 0;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  bit hold_off_req = 1'b0;

  thumb_data_processing_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_reg_at_bits_2_0  (in_reg_at_bits_2_0),
    .in_reg_at_bits_5_3  (in_reg_at_bits_5_3),
    .in_reg_at_bits_8_6  (in_reg_at_bits_8_6),
    .in_reg_at_bits_10_8 (in_reg_at_bits_10_8),
    .in_carry_in         (in_carry_in),
    .in_overflow_in      (in_overflow_in),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result          (out_result),
    .out_dest_index      (out_dest_index),
    .out_write_enable    (out_write_enable),
    .out_flag_n          (out_flag_n),
    .out_flag_z          (out_flag_z),
    .out_flag_c          (out_flag_c),
    .out_flag_v          (out_flag_v),
    .out_unsupported     (out_unsupported)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Returns {carry, value}.
  function automatic logic [32:0] predict_shift(logic [31:0] val, shift_kind_t kind,
                                                int unsigned amt, logic cin);
    logic [31:0] r;
    logic c;
    int unsigned n;
    r = val;
    c = cin;
    if (amt != 0) begin
      case (kind)
        SH_LSL: begin
          if (amt < 32) begin
            c = val[32 - amt];
            r = val << amt;
          end else begin
            c = (amt == 32) ? val[0] : 1'b0;
            r = '0;
          end
        end
        SH_LSR: begin
          if (amt < 32) begin
            c = val[amt - 1];
            r = val >> amt;
          end else begin
            c = (amt == 32) ? val[31] : 1'b0;
            r = '0;
          end
        end
        SH_ASR: begin
          if (amt < 32) begin
            c = val[amt - 1];
            r = 32'($signed(val) >>> amt);
          end else begin
            c = val[31];
            r = {32{val[31]}};
          end
        end
        default: begin
          n = amt % 32;
          if (n == 0) begin
            c = val[31];
          end else begin
            c = val[n - 1];
            r = (val >> n) | (val << (32 - n));
          end
        end
      endcase
    end
    return {c, r};
  endfunction

  // Returns {overflow, carry, sum}.
  function automatic logic [33:0] add_flags(logic [31:0] a, logic [31:0] b, logic cin);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    return {(a[31] ^ s[31]) & (b[31] ^ s[31]), s};
  endfunction

  function automatic exec_out_t predict_exec(exec_in_t x);
    exec_out_t y;
    logic [15:0] op;
    logic [31:0] opnd;
    logic [31:0] a;
    logic [31:0] b;
    logic [32:0] sh;
    logic [33:0] sum;
    logic c;
    logic v;
    logic use_sh;
    logic use_sum;
    int unsigned amt;
    op = x.opcode;
    y = '0;
    y.dest_index = op[2:0];
    y.write_enable = 1'b1;
    c = x.carry;
    v = x.overflow;
    use_sh = 1'b0;
    use_sum = 1'b0;
    sh = '0;
    sum = '0;
    a = x.reg_2_0;
    b = x.reg_5_3;
    if (op[15:13] == FMT12_TOP && op[12:11] == FMT2_SEL) begin
      opnd = op[10] ? {29'd0, op[8:6]} : x.reg_8_6;
      sum = op[9] ? add_flags(x.reg_5_3, ~opnd, 1'b1) : add_flags(x.reg_5_3, opnd, 1'b0);
      use_sum = 1'b1;
    end else if (op[15:13] == FMT12_TOP) begin
      amt = op[10:6];
      if (op[12:11] != SH_LSL && amt == 0) amt = 32;
      sh = predict_shift(x.reg_5_3, op[12:11], amt, x.carry);
      use_sh = 1'b1;
    end else if (op[15:13] == FMT3_TOP) begin
      opnd = {24'd0, op[7:0]};
      y.dest_index = op[10:8];
      if (op[12:11] == IMM_MOV) begin
        y.result = opnd;
      end else begin
        sum = (op[12:11] == IMM_ADD) ? add_flags(x.reg_10_8, opnd, 1'b0)
                                     : add_flags(x.reg_10_8, ~opnd, 1'b1);
        use_sum = 1'b1;
        y.write_enable = (op[12:11] != IMM_CMP);
      end
    end else if (op[15:10] == FMT4_PREFIX) begin
      amt = b[7:0];
      case (op[9:6])
        ALU_AND, ALU_TST: y.result = a & b;
        ALU_EOR: y.result = a ^ b;
        ALU_LSL: sh = predict_shift(a, SH_LSL, amt, x.carry);
        ALU_LSR: sh = predict_shift(a, SH_LSR, amt, x.carry);
        ALU_ASR: sh = predict_shift(a, SH_ASR, amt, x.carry);
        ALU_ROR: sh = predict_shift(a, SH_ROR, amt, x.carry);
        ALU_ADC: sum = add_flags(a, b, x.carry);
        ALU_SBC: sum = add_flags(a, ~b, x.carry);
        ALU_NEG: sum = add_flags(32'd0, ~b, 1'b1);
        ALU_CMP: sum = add_flags(a, ~b, 1'b1);
        ALU_CMN: sum = add_flags(a, b, 1'b0);
        ALU_ORR: y.result = a | b;
        ALU_MUL: y.result = a * b;
        ALU_BIC: y.result = a & ~b;
        default: y.result = ~b;
      endcase
      use_sh = (op[9:6] == ALU_LSL) || (op[9:6] == ALU_LSR) ||
               (op[9:6] == ALU_ASR) || (op[9:6] == ALU_ROR);
      use_sum = (op[9:6] == ALU_ADC) || (op[9:6] == ALU_SBC) || (op[9:6] == ALU_NEG) ||
                (op[9:6] == ALU_CMP) || (op[9:6] == ALU_CMN);
      y.write_enable = !((op[9:6] == ALU_TST) || (op[9:6] == ALU_CMP) ||
                         (op[9:6] == ALU_CMN));
    end else begin
      y.unsupported = 1'b1;
      y.write_enable = 1'b0;
      y.dest_index = '0;
    end
    if (use_sh) {c, y.result} = sh;
    if (use_sum) {v, c, y.result} = sum;
    y.flag_n = y.unsupported ? 1'b0 : y.result[31];
    y.flag_z = y.unsupported ? 1'b0 : (y.result == '0);
    y.flag_c = c;
    y.flag_v = v;
    return y;
  endfunction

  task automatic send_instr(input logic [15:0] op, input logic [31:0] r20,
                            input logic [31:0] r53, input logic [31:0] r86,
                            input logic [31:0] r108, input logic cf, input logic vf);
    exec_in_t item;
    item.opcode = op;
    item.reg_2_0 = r20;
    item.reg_5_3 = r53;
    item.reg_8_6 = r86;
    item.reg_10_8 = r108;
    item.carry = cf;
    item.overflow = vf;
    if (tx_idle_en && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_reg_at_bits_2_0 <= r20;
    in_reg_at_bits_5_3 <= r53;
    in_reg_at_bits_8_6 <= r86;
    in_reg_at_bits_10_8 <= r108;
    in_carry_in <= cf;
    in_overflow_in <= vf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_exec(item));
    instr_count++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: w = 32'h0000_0000;
      1: w = 32'hFFFF_FFFF;
      2: w = 32'h8000_0000;
      3: w = 32'h7FFF_FFFF;
      4: w = $urandom_range(0, 300);
      5: w[7:0] = 8'($urandom_range(28, 36));
      6: w[7:0] = 8'($urandom_range(0, 3) * 32);
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] rand_opcode();
    logic [15:0] op;
    op = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1: op = {FMT12_TOP, 2'($urandom_range(0, 2)), op[10:0]};
      2: op = {FMT12_TOP, FMT2_SEL, op[10:0]};
      3, 4: op = {FMT3_TOP, op[12:0]};
      5, 6, 7, 8: op = {FMT4_PREFIX, op[9:0]};
      default: ;
    endcase
    return op;
  endfunction

  task automatic send_random(int unsigned n, bit vary_idling);
    for (int unsigned i = 0; i < n; i++) begin
      if (vary_idling && i % 120 == 0) begin
        tx_idle_en = ($urandom_range(0, 2) != 0);
        rx_idle_en = ($urandom_range(0, 2) != 0);
      end
      send_instr(rand_opcode(), rand_operand(), rand_operand(), rand_operand(),
                 rand_operand(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_shift_immediate();
    send_instr({FMT12_TOP, SH_LSL, 5'd0, 3'd1, 3'd0}, $urandom, 32'h8000_0001,
               $urandom, $urandom, 1'b1, 1'b1);
    send_instr({FMT12_TOP, SH_LSR, 5'd0, 3'd2, 3'd7}, $urandom, 32'h8000_0000,
               $urandom, $urandom, 1'b0, 1'b0);
    send_instr({FMT12_TOP, SH_ASR, 5'd0, 3'd6, 3'd3}, $urandom, 32'hFFFF_FFFE,
               $urandom, $urandom, 1'b0, 1'b1);
  endtask

  task automatic test_add_subtract();
    send_instr({FMT12_TOP, FMT2_SEL, 1'b0, 1'b0, 3'd5, 3'd4, 3'd2}, $urandom,
               32'h7FFF_FFFF, 32'h0000_0001, $urandom, 1'b0, 1'b0);
    send_instr({FMT12_TOP, FMT2_SEL, 1'b1, 1'b1, 3'd7, 3'd0, 3'd1}, $urandom,
               32'h0000_0000, $urandom, $urandom, 1'b1, 1'b0);
  endtask

  task automatic test_immediate_ops();
    send_instr({FMT3_TOP, IMM_MOV, 3'd0, 8'h00}, $urandom, $urandom, $urandom,
               $urandom, 1'b1, 1'b1);
    send_instr({FMT3_TOP, IMM_CMP, 3'd5, 8'hFF}, $urandom, $urandom, $urandom,
               32'h0000_00FF, 1'b0, 1'b1);
    send_instr({FMT3_TOP, IMM_ADD, 3'd7, 8'hFF}, $urandom, $urandom, $urandom,
               32'hFFFF_FF01, 1'b0, 1'b0);
    send_instr({FMT3_TOP, IMM_SUB, 3'd3, 8'h01}, $urandom, $urandom, $urandom,
               32'h8000_0000, 1'b0, 1'b0);
  endtask

  task automatic test_register_alu();
    alu_op_t aop;
    logic [31:0] b;
    for (int k = 0; k < 16; k++) begin
      aop = alu_op_t'(k);
      case (aop)
        ALU_LSL: b = 32'h0000_0120;
        ALU_LSR: b = 32'hFFFF_FF21;
        ALU_ASR: b = 32'h0000_0100;
        ALU_ROR: b = 32'h0000_0040;
        default: b = 32'h8000_0001;
      endcase
      send_instr({FMT4_PREFIX, aop, 3'(k), 3'(k + 3)}, 32'hC000_0001, b, $urandom,
                 $urandom, 1'b1, aop[0]);
    end
  endtask

  task automatic test_unsupported();
    send_instr(OP_HI_REG_ADD, $urandom, $urandom, $urandom, $urandom, 1'b1, 1'b0);
    send_instr(OP_ALL_ONES, $urandom, $urandom, $urandom, $urandom, 1'b0, 1'b1);
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_off_req = 1'b1;
    send_random(40, 1'b0);
    wait_for_drain();
  endtask

  // Receiver side: random stall bursts and the long hold-off.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    exec_out_t act;
    exec_out_t exp;
    if (rst_n && out_valid && out_ready) begin
      act.result = out_result;
      act.dest_index = out_dest_index;
      act.write_enable = out_write_enable;
      act.flag_n = out_flag_n;
      act.flag_z = out_flag_z;
      act.flag_c = out_flag_c;
      act.flag_v = out_flag_v;
      act.unsupported = out_unsupported;
      if (pending_results.size() == 0) begin
        stray_count++;
        if (mismatch_count + stray_count <= MaxReports)
          $display("%0t: result beat with nothing expected: result %h", $time, out_result);
      end else begin
        exp = pending_results.pop_front();
        checked_count++;
        if (exp.unsupported) unsupported_count++;
        else if (!exp.write_enable) flag_only_count++;
        if (act.result !== exp.result || act.dest_index !== exp.dest_index ||
            act.write_enable !== exp.write_enable || act.flag_n !== exp.flag_n ||
            act.flag_z !== exp.flag_z || act.flag_c !== exp.flag_c ||
            act.flag_v !== exp.flag_v || act.unsupported !== exp.unsupported) begin
          mismatch_count++;
          if (mismatch_count + stray_count <= MaxReports) begin
            $display("%0t: mismatch on result %0d", $time, checked_count);
            $display("  expected result %h dest %0d we %b nzcv %b%b%b%b uns %b",
                     exp.result, exp.dest_index, exp.write_enable, exp.flag_n,
                     exp.flag_z, exp.flag_c, exp.flag_v, exp.unsupported);
            $display("  actual   result %h dest %0d we %b nzcv %b%b%b%b uns %b",
                     act.result, act.dest_index, act.write_enable, act.flag_n,
                     act.flag_z, act.flag_c, act.flag_v, act.unsupported);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("watchdog: no beat moved for %0d cycles", WatchdogLimit);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= '0;
    in_reg_at_bits_2_0 <= '0;
    in_reg_at_bits_5_3 <= '0;
    in_reg_at_bits_8_6 <= '0;
    in_reg_at_bits_10_8 <= '0;
    in_carry_in <= 1'b0;
    in_overflow_in <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_shift_immediate();
    test_add_subtract();
    test_immediate_ops();
    test_register_alu();
    test_unsupported();
    wait_for_drain();
    send_random(1000, 1'b1);
    wait_for_drain();
    test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(830, 1'b0);
    wait_for_drain();
    repeat (SettleCycles) @(posedge clk);
    $display("Checked %0d results from %0d instructions: %0d unsupported, %0d flag-only.",
             checked_count, instr_count, unsupported_count, flag_only_count);
    $display("Field mismatches: %0d, unexpected result beats: %0d.",
             mismatch_count, stray_count);
    if (mismatch_count == 0 && stray_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/tdpu_pkg.sv
rtl/core/tdpu_shifter.sv
rtl/core/tdpu_alu.sv
rtl/core/thumb_data_processing_unit.sv
tb/sv/thumb_data_processing_unit_test.sv
